>>> hw/rtl/nls_pkg.sv
// Shared constants, codes and controller/datapath types for the nearest level search.
package nls_pkg;

    localparam int MAX_LEVELS = 256;
    localparam int LVL_AW     = $clog2(MAX_LEVELS);
    localparam int NW         = $clog2(MAX_LEVELS + 1);

    localparam int IDX_W = 8;
    localparam int VAL_W = 32;
    localparam int CNT_W = 9;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        RA_ZERO,
        RA_LAST,
        RA_PROBE,
        RA_BELOW,
        RA_ABOVE
    } rd_sel_t;

    typedef enum logic [2:0]
    {
        RS_ZERO,
        RS_LAST,
        RS_MID,
        RS_BELOW,
        RS_ABOVE
    } res_sel_t;

    typedef struct packed
    {
        logic     q_load;
        logic     w_en;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     bounds_init;
        logic     mid_load;
        logic     hi_to_mid;
        logic     lo_past_mid;
        logic     tmid_load;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } nls_cmd_t;

    typedef struct packed
    {
        logic v_lt_rd;
        logic v_gt_rd;
        logic v_eq_rd;
        logic sum_gt;
        logic lo_lt_hi;
        logic mid_nonzero;
        logic mid_has_above;
    } nls_stat_t;

endpackage

>>> hw/rtl/nls_if.sv
// Channel interfaces for the query, result and configuration ports.
interface nls_req_if import nls_pkg::*; ();
    logic                    valid;
    logic                    ready;
    op_t                     op;
    logic [IDX_W-1:0]        level_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output level_index, output value, input ready);
    modport sink   (input valid, input op, input level_index, input value, output ready);
endinterface

interface nls_rsp_if import nls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] nearest_index;

    modport source (output valid, output nearest_index, input ready);
    modport sink   (input valid, input nearest_index, output ready);
endinterface

interface nls_cfg_if import nls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] level_count;

    modport source (output valid, output level_count, input ready);
    modport sink   (input valid, input level_count, output ready);
endinterface

>>> hw/rtl/nls_ctrl.sv
// Search controller: sequences table reads, bound updates and result hand-off.
module nls_ctrl import nls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  op_t       req_op,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output nls_cmd_t  cmd,
    input  nls_stat_t stat
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_PROBE,
        S_MID,
        S_NBR,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   below_reg, below_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        below_next     = below_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_op == OP_QUERY)
                    begin
                        cmd.q_load = 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_ZERO;
                        state_next = S_FIRST;
                    end
                    else
                    begin
                        cmd.w_en = 1'b1;
                    end
                end
            end
            S_FIRST:
            begin
                if (!stat.v_gt_rd)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RS_ZERO;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_LAST;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!stat.v_lt_rd)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RS_LAST;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.bounds_init = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.mid_load = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RA_PROBE;
                    state_next   = S_MID;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RS_MID;
                    state_next   = S_RESULT;
                end
            end
            S_MID:
            begin
                if (stat.v_eq_rd)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RS_MID;
                    state_next   = S_RESULT;
                end
                else if (stat.v_lt_rd)
                begin
                    cmd.tmid_load = 1'b1;
                    below_next    = 1'b1;
                    if (stat.mid_nonzero)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_BELOW;
                        state_next = S_NBR;
                    end
                    else
                    begin
                        cmd.hi_to_mid = 1'b1;
                        state_next    = S_PROBE;
                    end
                end
                else
                begin
                    cmd.tmid_load = 1'b1;
                    below_next    = 1'b0;
                    if (stat.mid_has_above)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_ABOVE;
                        state_next = S_NBR;
                    end
                    else
                    begin
                        cmd.lo_past_mid = 1'b1;
                        state_next      = S_PROBE;
                    end
                end
            end
            S_NBR:
            begin
                if (below_reg)
                begin
                    if (stat.v_gt_rd)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = stat.sum_gt ? RS_BELOW : RS_MID;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        cmd.hi_to_mid = 1'b1;
                        state_next    = S_PROBE;
                    end
                end
                else
                begin
                    if (stat.v_lt_rd)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = stat.sum_gt ? RS_MID : RS_ABOVE;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        cmd.lo_past_mid = 1'b1;
                        state_next      = S_PROBE;
                    end
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            below_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            below_reg     <= below_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> hw/rtl/nls_dp.sv
// Search datapath: level memory, search bounds, comparators and result registers.
module nls_dp import nls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CNT_W-1:0]        cfg_level_count,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        req_level_index,
    input  logic signed [VAL_W-1:0] req_value,
    output logic [IDX_W-1:0]        rsp_nearest_index,
    input  nls_cmd_t                cmd,
    output nls_stat_t               stat
);

    logic signed [VAL_W-1:0] level_mem [MAX_LEVELS];

    logic [CNT_W-1:0]        level_count_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [VAL_W-1:0] rdata_reg;
    logic signed [VAL_W-1:0] tmid_reg;
    logic [NW-1:0]           n_reg;
    logic [NW-1:0]           lo_reg;
    logic [NW-1:0]           hi_reg;
    logic [NW-1:0]           mid_reg;
    logic [NW-1:0]           res_reg;
    logic [IDX_W-1:0]        out_idx_reg;

    logic [NW-1:0]           eff_count;
    logic [NW:0]             mid_sum;
    logic [NW-1:0]           mid_next;
    logic [NW-1:0]           mid_dec;
    logic [NW-1:0]           mid_inc;
    logic [LVL_AW-1:0]       rd_addr;
    logic                    wr_ok;
    logic signed [VAL_W:0]   pair_sum;
    logic signed [VAL_W:0]   twice_v;
    logic [NW-1:0]           res_next;

    assign cfg_ready         = 1'b1;
    assign rsp_nearest_index = out_idx_reg;

    // A count of zero means one level; anything past the table means the whole table.
    always_comb
    begin
        if (level_count_reg == '0)
        begin
            eff_count = NW'(1);
        end
        else if (32'(level_count_reg) > MAX_LEVELS)
        begin
            eff_count = NW'(MAX_LEVELS);
        end
        else
        begin
            eff_count = NW'(level_count_reg);
        end
    end

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next = mid_sum[NW:1];
    assign mid_dec  = mid_reg - NW'(1);
    assign mid_inc  = mid_reg + NW'(1);
    assign wr_ok    = (32'(req_level_index) < MAX_LEVELS);

    always_comb
    begin
        case (cmd.rd_sel)
            RA_ZERO:  rd_addr = '0;
            RA_LAST:  rd_addr = LVL_AW'(n_reg - NW'(1));
            RA_PROBE: rd_addr = LVL_AW'(mid_next);
            RA_BELOW: rd_addr = LVL_AW'(mid_dec);
            RA_ABOVE: rd_addr = LVL_AW'(mid_inc);
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.res_sel)
            RS_ZERO:  res_next = '0;
            RS_LAST:  res_next = n_reg - NW'(1);
            RS_MID:   res_next = mid_reg;
            RS_BELOW: res_next = mid_dec;
            RS_ABOVE: res_next = mid_inc;
            default:  res_next = mid_reg;
        endcase
    end

    // The sum of two levels against twice the value needs one extra bit and never overflows.
    assign pair_sum = {tmid_reg[VAL_W-1], tmid_reg} + {rdata_reg[VAL_W-1], rdata_reg};
    assign twice_v  = {v_reg, 1'b0};

    assign stat.v_lt_rd       = (v_reg < rdata_reg);
    assign stat.v_gt_rd       = (v_reg > rdata_reg);
    assign stat.v_eq_rd       = (v_reg == rdata_reg);
    assign stat.sum_gt        = (pair_sum > twice_v);
    assign stat.lo_lt_hi      = (lo_reg < hi_reg);
    assign stat.mid_nonzero   = (mid_reg != '0);
    assign stat.mid_has_above = ({1'b0, mid_reg} + (NW+1)'(1) < {1'b0, n_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.w_en && wr_ok)
        begin
            level_mem[LVL_AW'(req_level_index)] <= req_value;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= level_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            level_count_reg <= cfg_level_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            v_reg <= req_value;
            n_reg <= eff_count;
        end
        if (cmd.bounds_init)
        begin
            lo_reg <= '0;
            hi_reg <= n_reg;
        end
        if (cmd.hi_to_mid)
        begin
            hi_reg <= mid_reg;
        end
        if (cmd.lo_past_mid)
        begin
            lo_reg <= mid_inc;
        end
        if (cmd.mid_load)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.tmid_load)
        begin
            tmid_reg <= rdata_reg;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_idx_reg <= IDX_W'(res_reg);
        end
    end

endmodule

>>> hw/rtl/nearest_level_search_top.sv
// Top level of the nearest level search: controller, datapath and channel ports.
//
// The block holds a table of up to 256 signed 32-bit levels, to be loaded by the user in
// strictly ascending order by write beats (op = 0), an order the block itself does not
// check, and answers each query beat (op = 1) with the index of the level nearest the
// value among the first level_count levels; a value exactly halfway between two levels
// gives the higher index. A write beat gives no result. A query is settled by a binary
// search on the level memory, whose single read port delivers one registered entry per
// cycle: the first and last levels are checked first, and each halving step then reads
// the probe and, where needed, its neighbour. The result waits in an output register, so
// the next beat is taken once a result has moved there, even while it has not yet been
// collected; a search that ends while an earlier result still waits holds until that
// result is taken. level_count is written through its own channel; the user must
// write it only while the block is idle, which the block itself does not enforce. Zero
// is read as one and values beyond the table size as the full table. Entries that have
// never been written hold no defined value, and queries must not reach them.
module nearest_level_search_top import nls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nls_req_if.sink   req,
    nls_rsp_if.source rsp,
    nls_cfg_if.sink   cfg
);

    nls_cmd_t  cmd;
    nls_stat_t stat;

    // The controller owns req/rsp handshakes; the datapath owns cfg, table and payload.
    nls_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    nls_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg.valid),
        .cfg_level_count   (cfg.level_count),
        .cfg_ready         (cfg.ready),
        .req_level_index   (req.level_index),
        .req_value         (req.value),
        .rsp_nearest_index (rsp.nearest_index),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

>>> hw/rtl/nls_checker.sv
// Port-level assertions for the nearest level search, bound to the top level.
module nls_checker import nls_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input op_t              req_op,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [IDX_W-1:0] rsp_nearest_index,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CNT_W-1:0] cfg_level_count
);

    logic [CNT_W-1:0] count_reg;
    logic [1:0]       pending_reg;
    logic [NW-1:0]    eff_count;
    logic             query_beat;
    logic             rsp_beat;

    assign query_beat = req_valid && req_ready && (req_op == OP_QUERY);
    assign rsp_beat   = rsp_valid && rsp_ready;

    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = NW'(1);
        end
        else if (32'(count_reg) > MAX_LEVELS)
        begin
            eff_count = NW'(MAX_LEVELS);
        end
        else
        begin
            eff_count = NW'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CNT_W'(1);
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_level_count;
            end
            pending_reg <= pending_reg + {1'b0, query_beat} - {1'b0, rsp_beat};
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_index))
        else $error("result beat changed while stalled");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_nearest_index) < 32'(eff_count)))
        else $error("nearest index beyond the levels in use");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_beat |=> !req_ready)
        else $error("new beat taken while a search is running");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != '0))
        else $error("result offered without an outstanding query");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two queries outstanding");

endmodule

bind nearest_level_search_top nls_checker u_nls_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_op            (req.op),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_nearest_index (rsp.nearest_index),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_level_count   (cfg.level_count)
);
